FILE: hdl/assert_macros.svh
// Assertion macros shared by the hash block.
// Depends on signals named clk and rst_n in the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/fnv2l_pkg.sv
// Package for the two-lane FNV-1a 32-bit hash: constants, block descriptor, helpers.
// No dependencies.
package fnv2l_pkg;

    localparam logic [31:0] HASH_PRIME  = 32'd709607;
    localparam logic [31:0] SEED_RESET  = 32'h811C9DC5;
    localparam int          QUEUE_DEPTH = 2;
    localparam logic [4:0]  FULL_BYTES  = 5'd16;

    // Step bits in the descriptor mask, executed lowest first
    localparam int STEP_W32 = 0;  // 32-bit op on both lanes (also the full-block mix)
    localparam int STEP_H16 = 1;  // 16-bit op on both lanes
    localparam int STEP_A16 = 2;  // 16-bit op on lane A
    localparam int STEP_A8  = 3;  // byte op on lane A

    // One classified block, as queued between front and back
    typedef struct packed {
        logic        first;
        logic        last;
        logic [3:0]  mask;
        logic [31:0] key_length;
        logic [31:0] op0a;
        logic [31:0] op0b;
        logic [15:0] op1a;
        logic [15:0] op1b;
        logic [15:0] op2;
        logic [7:0]  op3;
    } desc_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

    typedef struct packed {
        logic busy;
        logic fin_pending;
    } back_status_t;

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

endpackage

FILE: hdl/fnv2l_front.sv
// Front end: accepts key blocks, classifies them and builds queue descriptors.
// Depends on fnv2l_pkg.
module fnv2l_front (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic [31:0]              word0,
    input  logic [31:0]              word1,
    input  logic [31:0]              word2,
    input  logic [31:0]              word3,
    input  logic [4:0]               valid_bytes,
    input  logic                     last_block,
    input  logic [31:0]              key_length,
    input  fnv2l_pkg::queue_status_t q_status,
    output logic                     push,
    output fnv2l_pkg::desc_t         push_desc
);

    logic        at_key_start_reg;
    logic        at_key_start_next;
    logic [4:0]  cnt;
    logic        tail;
    logic [1:0]  idx;
    logic [31:0] w [4];

    assign in_ready = !q_status.full;
    assign push     = in_valid && in_ready;

    // Clamp byte count; a tail applies only on a short last block
    assign cnt  = (valid_bytes > fnv2l_pkg::FULL_BYTES) ? fnv2l_pkg::FULL_BYTES : valid_bytes;
    assign tail = last_block && (cnt != fnv2l_pkg::FULL_BYTES);
    assign idx  = cnt[3:2];

    always_comb
    begin
        w[0] = word0;
        w[1] = word1;
        w[2] = word2;
        w[3] = word3;
    end

    // Descriptor build: offsets of the tail pieces follow from the count bits
    always_comb
    begin
        push_desc            = '0;
        push_desc.first      = at_key_start_reg;
        push_desc.last       = last_block;
        push_desc.key_length = key_length;
        if (!tail)
        begin
            push_desc.mask                     = '0;
            push_desc.mask[fnv2l_pkg::STEP_W32] = 1'b1;
            push_desc.op0a = fnv2l_pkg::rotl5(word0) ^ word1;
            push_desc.op0b = fnv2l_pkg::rotl5(word2) ^ word3;
        end
        else
        begin
            push_desc.mask[fnv2l_pkg::STEP_W32] = cnt[3];
            push_desc.mask[fnv2l_pkg::STEP_H16] = cnt[2];
            push_desc.mask[fnv2l_pkg::STEP_A16] = cnt[1];
            push_desc.mask[fnv2l_pkg::STEP_A8]  = cnt[0];
            push_desc.op0a = word0;
            push_desc.op0b = word1;
            // halfword pair sits at byte 8 after an 8-byte step, else at byte 0
            push_desc.op1a = cnt[3] ? word2[15:0]  : word0[15:0];
            push_desc.op1b = cnt[3] ? word2[31:16] : word0[31:16];
            push_desc.op2  = w[idx][15:0];
            push_desc.op3  = cnt[1] ? w[idx][23:16] : w[idx][7:0];
        end
    end

    // Key-start tracking
    assign at_key_start_next = push ? last_block : at_key_start_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            at_key_start_reg <= 1'b1;
        else
            at_key_start_reg <= at_key_start_next;
    end

endmodule

FILE: hdl/fnv2l_queue.sv
// Short descriptor queue that decouples the front end from the back end.
// Depends on fnv2l_pkg.
module fnv2l_queue #(
    parameter int DEPTH = fnv2l_pkg::QUEUE_DEPTH
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     push,
    input  fnv2l_pkg::desc_t         push_desc,
    input  logic                     pop,
    output fnv2l_pkg::desc_t         head,
    output fnv2l_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    fnv2l_pkg::desc_t entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_W'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign head         = entry_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (push && !pop)
            count_next = count_reg + CNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_desc;
    end

endmodule

FILE: hdl/fnv2l_back.sv
// Back end: runs the lane mix steps of each descriptor, the final mix and the fold.
// Holds the seed register. Depends on fnv2l_pkg.
module fnv2l_back (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [31:0]             cfg_data,
    input  logic                    q_valid,
    output logic                    q_ready,
    input  fnv2l_pkg::desc_t        head,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [31:0]             hash_value,
    output fnv2l_pkg::back_status_t status
);

    logic [31:0]      seed_reg;
    logic [31:0]      lane_a_reg, lane_b_reg;
    logic             busy_reg;
    logic             fin_reg;
    logic [3:0]       mask_reg;
    fnv2l_pkg::desc_t desc_reg;
    logic             out_valid_reg;
    logic [31:0]      prod_reg;

    logic             pop;
    logic             out_free;
    logic             do_step;
    logic             do_fin;
    logic             use_b;
    logic [3:0]       mask_next;
    logic [31:0]      op_a, op_b;
    logic [31:0]      mix_a, mix_b;
    logic [31:0]      prod_a, prod_b;

    assign cfg_ready = 1'b1;
    assign q_ready   = !busy_reg;
    assign pop       = q_valid && q_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign do_step   = busy_reg && (mask_reg != '0);
    assign do_fin    = busy_reg && (mask_reg == '0) && fin_reg && out_free;
    assign mask_next = mask_reg & (mask_reg - 4'd1);

    assign status.busy        = busy_reg;
    assign status.fin_pending = fin_reg;

    // Operand select: lowest pending step, else the final mix
    always_comb
    begin
        op_a  = fnv2l_pkg::rotl5(lane_b_reg);
        op_b  = '0;
        use_b = 1'b0;
        if (mask_reg[fnv2l_pkg::STEP_W32])
        begin
            op_a  = desc_reg.op0a;
            op_b  = desc_reg.op0b;
            use_b = 1'b1;
        end
        else if (mask_reg[fnv2l_pkg::STEP_H16])
        begin
            op_a  = {16'd0, desc_reg.op1a};
            op_b  = {16'd0, desc_reg.op1b};
            use_b = 1'b1;
        end
        else if (mask_reg[fnv2l_pkg::STEP_A16])
            op_a = {16'd0, desc_reg.op2};
        else if (mask_reg[fnv2l_pkg::STEP_A8])
            op_a = {24'd0, desc_reg.op3};
    end

    // One multiply per lane, registered into the lane
    assign mix_a  = lane_a_reg ^ op_a;
    assign mix_b  = lane_b_reg ^ op_b;
    assign prod_a = mix_a * fnv2l_pkg::HASH_PRIME;
    assign prod_b = mix_b * fnv2l_pkg::HASH_PRIME;

    // Sequencer control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= fnv2l_pkg::SEED_RESET;
            busy_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                seed_reg <= cfg_data;
            if (pop)
            begin
                busy_reg <= 1'b1;
                fin_reg  <= head.last;
                mask_reg <= head.mask;
            end
            else if (do_step)
            begin
                mask_reg <= mask_next;
                busy_reg <= (mask_next != '0) || fin_reg;
            end
            else if (do_fin)
            begin
                fin_reg  <= 1'b0;
                busy_reg <= 1'b0;
            end
            if (do_fin)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Lane and result datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lane_a_reg <= '0;
            lane_b_reg <= '0;
        end
        else if (pop)
        begin
            if (head.first)
            begin
                lane_a_reg <= seed_reg;
                lane_b_reg <= head.key_length;
            end
        end
        else if (do_step)
        begin
            lane_a_reg <= prod_a;
            if (use_b)
                lane_b_reg <= prod_b;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            desc_reg <= head;
        if (do_fin)
            prod_reg <= prod_a;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = prod_reg ^ {16'd0, prod_reg[31:16]};

endmodule

FILE: hdl/fnv1a_two_lane_hash32.sv
// Top level of the two-lane FNV-1a 32-bit hash.
// Depends on fnv2l_pkg, fnv2l_front, fnv2l_queue, fnv2l_back and assert_macros.svh.
//
// A key enters as 16-byte blocks, one beat per block, and the hash leaves as one
// beat on the key's last block. The front end takes a block whenever the descriptor
// queue (QUEUE_DEPTH entries) has room. The back end owns both lanes and one 32-bit
// multiply by the prime per lane per cycle. It loads a descriptor only while idle,
// runs its mix steps lowest mask bit first (1 for a full last block, 0 to 4
// otherwise) and, on a last block, then writes the final mix into the output
// register. That final mix waits while the output register still holds a hash
// that has not been taken. The seed is written through the cfg channel, which
// is always ready.
`include "assert_macros.svh"

module fnv1a_two_lane_hash32 #(
    parameter int QUEUE_DEPTH = fnv2l_pkg::QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [31:0] word0,
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [31:0] word3,
    input  logic [4:0]  valid_bytes,
    input  logic        last_block,
    input  logic [31:0] key_length,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    logic                     push;
    logic                     pop;
    logic                     q_ready;
    fnv2l_pkg::desc_t         push_desc;
    fnv2l_pkg::desc_t         head;
    fnv2l_pkg::queue_status_t q_status;
    fnv2l_pkg::back_status_t  b_status;

    assign pop = !q_status.empty && q_ready;

    fnv2l_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .word0       (word0),
        .word1       (word1),
        .word2       (word2),
        .word3       (word3),
        .valid_bytes (valid_bytes),
        .last_block  (last_block),
        .key_length  (key_length),
        .q_status    (q_status),
        .push        (push),
        .push_desc   (push_desc)
    );

    fnv2l_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_desc (push_desc),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    fnv2l_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .q_valid    (!q_status.empty),
        .q_ready    (q_ready),
        .head       (head),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .hash_value (hash_value),
        .status     (b_status)
    );

    // A pushed descriptor is visible in the queue on the next cycle
    `ASSERT_NEXT(a_push_lands, push, !q_status.empty, "pushed descriptor missing from queue")
    // A popped descriptor puts the back end to work
    `ASSERT_NEXT(a_pop_busy, pop, b_status.busy, "back end idle after descriptor pop")
    // A new hash only appears out of a busy back end with a final mix pending
    `ASSERT_IMPL(a_out_source, $rose(out_valid), $past(b_status.busy && b_status.fin_pending),
        "hash presented without a final mix")

endmodule

FILE: bench/fnv1a_hash_checker.sv
// Checker for the two-lane FNV-1a 32-bit hash: watches the cfg, block and hash channels,
// predicts each hash from its own copy of the lanes and seed, and counts mismatches.
// Depends on nothing but its ports.
module fnv1a_hash_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [31:0] word0,
    input  logic [31:0] word1,
    input  logic [31:0] word2,
    input  logic [31:0] word3,
    input  logic [4:0]  valid_bytes,
    input  logic        last_block,
    input  logic [31:0] key_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [31:0] hash_value,
    output int          pending,
    output int          fail_count
);

    localparam logic [31:0] MIX_PRIME     = 32'd709607;
    localparam logic [31:0] SEED_AT_RESET = 32'h811C9DC5;
    localparam int          REPORT_MAX    = 10;

    logic [31:0] seed_reg;
    logic [31:0] lane_a;
    logic [31:0] lane_b;
    logic        key_start;
    logic [31:0] hashes_due[$];
    int          fails;

    function automatic logic [31:0] rot5(input logic [31:0] x);
        return {x[26:0], x[31:27]};
    endfunction

    // Little-endian byte pickers over the 16-byte block, offsets wrap at 16
    function automatic logic [31:0] byte_at(input logic [127:0] blk, input int off);
        return {24'd0, blk[8 * (off % 16) +: 8]};
    endfunction

    function automatic logic [31:0] half_at(input logic [127:0] blk, input int off);
        return byte_at(blk, off) | (byte_at(blk, off + 1) << 8);
    endfunction

    function automatic logic [31:0] word_at(input logic [127:0] blk, input int off);
        return half_at(blk, off) | (half_at(blk, off + 2) << 16);
    endfunction

    // Fold the block on the input ports into the lanes; a last block yields a hash
    task automatic absorb_block(output bit done, output logic [31:0] digest);
        logic [127:0] blk;
        logic [4:0]   tail;
        logic [31:0]  a;
        logic [31:0]  b;
        int           off;
        blk  = {word3, word2, word1, word0};
        tail = (valid_bytes > 5'd16) ? 5'd16 : valid_bytes;
        off  = 0;
        if (key_start) begin
            lane_a    = seed_reg;
            lane_b    = key_length;
            key_start = 1'b0;
        end
        a = lane_a;
        b = lane_b;
        if (!last_block || tail == 5'd16) begin
            a = (a ^ (rot5(word0) ^ word1)) * MIX_PRIME;
            b = (b ^ (rot5(word2) ^ word3)) * MIX_PRIME;
        end
        else begin
            if (tail[3]) begin
                a   = (a ^ word_at(blk, off)) * MIX_PRIME;
                b   = (b ^ word_at(blk, off + 4)) * MIX_PRIME;
                off = off + 8;
            end
            if (tail[2]) begin
                a   = (a ^ half_at(blk, off)) * MIX_PRIME;
                b   = (b ^ half_at(blk, off + 2)) * MIX_PRIME;
                off = off + 4;
            end
            if (tail[1]) begin
                a   = (a ^ half_at(blk, off)) * MIX_PRIME;
                off = off + 2;
            end
            if (tail[0])
                a = (a ^ byte_at(blk, off)) * MIX_PRIME;
        end
        lane_a = a;
        lane_b = b;
        done   = last_block;
        digest = 32'd0;
        if (last_block) begin
            a         = (a ^ rot5(b)) * MIX_PRIME;
            digest    = a ^ (a >> 16);
            key_start = 1'b1;
        end
    endtask

    // Watch all three channels at each edge
    always @(posedge clk or negedge rst_n) begin : watch
        logic [31:0] want;
        logic [31:0] digest;
        bit          done;
        if (!rst_n) begin
            seed_reg   = SEED_AT_RESET;
            lane_a     = 32'd0;
            lane_b     = 32'd0;
            key_start  = 1'b1;
            fails      = 0;
            hashes_due.delete();
            pending    <= 0;
            fail_count <= 0;
        end
        else begin
            // Hash beat against the oldest prediction
            if (out_valid && out_ready) begin
                if (hashes_due.size() == 0) begin
                    fails++;
                    if (fails <= REPORT_MAX)
                        $display("unexpected hash beat: got %h", hash_value);
                end
                else begin
                    want = hashes_due.pop_front();
                    if (hash_value !== want) begin
                        fails++;
                        if (fails <= REPORT_MAX)
                            $display("hash mismatch: expected %h, got %h", want, hash_value);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
                seed_reg = cfg_data;
            if (in_valid && in_ready) begin
                absorb_block(done, digest);
                if (done)
                    hashes_due.push_back(digest);
            end
            pending    <= hashes_due.size();
            fail_count <= fails;
        end
    end

endmodule

FILE: bench/tb_fnv1a_two_lane_hash32.sv
// Testbench top for the two-lane FNV-1a 32-bit hash: clock, reset, block and seed
// stimulus, hash-side back-pressure and the verdict.
// Depends on fnv1a_two_lane_hash32 (and its package) and fnv1a_hash_checker.
module tb_fnv1a_two_lane_hash32;

    localparam int LIMIT        = 300000;
    localparam int DRAIN        = 24;
    localparam int RANDOM_BEATS = 1200;
    localparam int CALM_AFTER   = 1000;
    localparam int PHASES       = 6;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [31:0] word0;
    logic [31:0] word1;
    logic [31:0] word2;
    logic [31:0] word3;
    logic [4:0]  valid_bytes;
    logic        last_block;
    logic [31:0] key_length;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] hash_value;
    int          pending;
    int          fail_count;

    int          cycles;
    int          blocks_sent;
    bit          calm;
    bit          lazy;

    fnv1a_two_lane_hash32 uut (.*);

    fnv1a_hash_checker checker_i (.*);

    initial clk = 1'b0;
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Hash-side back-pressure: random stall bursts until the calm tail of the run
    initial begin
        int stall_left;
        bit rdy;
        out_ready  = 1'b0;
        stall_left = 0;
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (stall_left > 0) begin
                stall_left--;
                rdy = 1'b0;
            end
            else if (!calm && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(1, 5) - 1;
                rdy = 1'b0;
            end
            else
                rdy = 1'b1;
            out_ready <= rdy;
        end
    end

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 9))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // One block beat; valid stays up through the accepting edge
    task automatic push_block(input logic [31:0] w0, input logic [31:0] w1,
                              input logic [31:0] w2, input logic [31:0] w3,
                              input logic [4:0] vb, input logic last,
                              input logic [31:0] klen);
        in_valid    <= 1'b1;
        word0       <= w0;
        word1       <= w1;
        word2       <= w2;
        word3       <= w3;
        valid_bytes <= vb;
        last_block  <= last;
        key_length  <= klen;
        do @(negedge clk); while (!in_ready);
        @(posedge clk);
        blocks_sent++;
        if (!calm && lazy && $urandom_range(0, 2) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
    endtask

    // Wait out every expected hash, then the blocks still in flight
    task automatic settle_pipeline();
        in_valid <= 1'b0;
        do @(negedge clk); while (pending != 0);
        repeat (DRAIN) @(posedge clk);
    endtask

    task automatic load_seed(input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(negedge clk); while (!cfg_ready);
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    // A whole key: body blocks then the last block, length usually consistent
    task automatic hash_key(input int body, input bit honest_len);
        logic [4:0]  tail;
        logic [31:0] klen;
        tail = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                           : 5'($urandom_range(0, 16));
        klen = honest_len ? 32'(body * 16 + ((tail > 5'd16) ? 16 : int'(tail))) : $urandom;
        for (int i = 0; i < body; i++)
            push_block(pick_word(), pick_word(), pick_word(), pick_word(),
                       5'($urandom_range(0, 31)), 1'b0, (i == 0) ? klen : $urandom);
        push_block(pick_word(), pick_word(), pick_word(), pick_word(),
                   tail, 1'b1, (body == 0) ? klen : $urandom);
    endtask

    initial begin
        int          tails[19] = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15, 16,
                                   17, 31};
        int          phase_end;
        logic [31:0] w;
        rst_n       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_data    = 32'd0;
        in_valid    = 1'b0;
        word0       = 32'd0;
        word1       = 32'd0;
        word2       = 32'd0;
        word3       = 32'd0;
        valid_bytes = 5'd0;
        last_block  = 1'b0;
        key_length  = 32'd0;
        calm        = 1'b0;
        lazy        = 1'b1;
        blocks_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Single-block keys under the reset seed: every tail length, counts above
        // sixteen, distinct byte patterns so a wrong byte pick shows up
        foreach (tails[i]) begin
            w = (i % 4 == 3) ? 32'hFFFF_FFFF : 32'h0302_0100 + 32'h0404_0404 * i;
            push_block(w, w + 32'h0404_0404, w + 32'h0808_0808, w + 32'h0C0C_0C0C,
                       5'(tails[i]), 1'b1, (i % 5 == 4) ? 32'hFFFF_FFFF : tails[i]);
        end

        // Zero seed, multi-block key with a length that disagrees with the tail
        settle_pipeline();
        load_seed(32'h0000_0000);
        push_block(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   5'd31, 1'b0, 32'd0);
        push_block(32'h0, 32'h0, 32'h0, 32'h0, 5'd0, 1'b0, 32'hFFFF_FFFF);
        push_block(32'h8877_6655, 32'h4433_2211, 32'hDEAD_BEEF, 32'h0BAD_F00D,
                   5'd5, 1'b1, 32'd7);

        // Seed rewritten mid-key must not touch the open key
        push_block(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F1E_2D3C, 32'h4B5A_6978,
                   5'd3, 1'b0, 32'd27);
        settle_pipeline();
        load_seed(32'hFFFF_FFFF);
        push_block(32'hCAFE_BABE, 32'h0102_0304, 32'hA5A5_5A5A, 32'h7F80_017E,
                   5'd11, 1'b1, 32'd27);

        // Random keys in phases, seed changed between phases
        for (int p = 0; p < PHASES; p++) begin
            phase_end = blocks_sent + RANDOM_BEATS / PHASES;
            while (blocks_sent < phase_end) begin
                calm = (blocks_sent >= CALM_AFTER);
                lazy = ($urandom_range(0, 3) != 0);
                hash_key($urandom_range(0, 3), $urandom_range(0, 3) != 0);
            end
            if (p % 2 == 1) begin
                push_block(pick_word(), pick_word(), pick_word(), pick_word(),
                           5'($urandom_range(0, 31)), 1'b0, $urandom);
                settle_pipeline();
                load_seed((p == 1) ? 32'hFFFF_FFFF : $urandom);
                push_block(pick_word(), pick_word(), pick_word(), pick_word(),
                           5'($urandom_range(0, 16)), 1'b1, $urandom);
            end
            else begin
                settle_pipeline();
                load_seed((p == 0) ? 32'h0000_0000 : $urandom);
            end
        end

        settle_pipeline();
        @(negedge clk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
